// ===== src/bac_pkg.sv =====
// shared types and constants for the barometric altitude unit
`default_nettype none

package bac_pkg;

   // datapath word and field widths
   localparam int unsigned WORD_W = 64;
   localparam int unsigned DIV_NUM_W = 2 * WORD_W;
   localparam int unsigned ALT_W = 19;
   localparam int unsigned PRES_W = 19;
   localparam int unsigned OFS_W = 17;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned CNT_W = 7;
   localparam int unsigned K_W = 5;
   localparam int unsigned TDATA_W = 40;
   localparam int unsigned TUSER_W = 2;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CALIBRATE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SET_REF = 2'd2;

   // ranges and fixed numbers of the altitude formula
   localparam logic signed [ALT_W-1:0] ALT_MIN = -19'sd131072;
   localparam logic signed [ALT_W-1:0] ALT_MAX = 19'sd262143;
   localparam logic [PRES_W-1:0] P_MAX = 19'd524287;
   localparam logic [PRES_W-1:0] REF_RESET = 19'd405300;
   localparam logic [WORD_W-1:0] CAL_DIVISOR = 64'd70929232;
   localparam logic [K_W-1:0] SERIES_TERMS = 5'd24;
   localparam logic [CNT_W-1:0] SHIFT_CAP_POS = 7'd20;
   localparam logic [CNT_W-1:0] SHIFT_CAP_NEG = 7'd64;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ALT_START,
      ST_ALT_LOG2,
      ST_ALT_SMUL,
      ST_ALT_SMUL_W,
      ST_ALT_H,
      ST_ALT_H_W,
      ST_CAL_DIV,
      ST_CAL_DIV_W,
      ST_CAL_SMUL,
      ST_CAL_SMUL_W,
      ST_CAL_P0,
      ST_CAL_P0_W,
      ST_LOG_NORM,
      ST_LOG_SQ,
      ST_LOG_SQ_W,
      ST_EXP_Y,
      ST_EXP_Y_W,
      ST_EXP_T,
      ST_EXP_T_W,
      ST_EXP_K_W,
      ST_EXP_SH,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// ===== src/barometric_altitude_with_calibration_unit.sv =====
// top level: sequencer, state and stream ports of the barometric altimeter
// One item is taken at a time. A pressure sample or reference setting that changes the state
// runs two base-2 logarithms and one 2^x evaluation. Each logarithm normalizes one bit per
// cycle, then does INTERNAL_FRACTION_BITS squarings. A calibration runs one logarithm, one
// 2^x and up to two divisions. The 2^x series dominates: 24 terms, each a multiply and a pass
// of the shared divider. A rejected calibration stops after its first division. Other items
// that change nothing go from the idle state through the decide state to the result state; a
// sample or reference setting that meets a zero pressure or reference also passes through the
// altitude start state. A result waits in an output register, so the next item is taken
// while it is still pending. Altitudes are in 1/16 m, pressures in 1/4 Pa.
`default_nettype none

module barometric_altitude_with_calibration_unit #(
   parameter int unsigned INTERNAL_FRACTION_BITS = 30
) (
   input  wire                          clock,
   input  wire                          reset,
   // req_tdata: pressure_value[18:0], known_altitude[37:19]
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [bac_pkg::TDATA_W-1:0]   req_tdata,
   // req_tuser: kind[1:0]
   input  wire [bac_pkg::TUSER_W-1:0]   req_tuser,
   // rsp_tdata: altitude[18:0], reference_pressure[37:19]
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [bac_pkg::TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: altitude_updated[0], calibration_error[1]
   output logic [bac_pkg::TUSER_W-1:0]  rsp_tuser,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [bac_pkg::OFS_W-1:0]     csr_wdata
);
   import bac_pkg::*;

   localparam int unsigned F = INTERNAL_FRACTION_BITS;
   localparam logic [DIV_NUM_W-1:0] LN2_WIDE = (128'd69314718056 << F) / 128'd100000000000;
   localparam logic [DIV_NUM_W-1:0] EXP_WIDE = (128'd190263 << F) / 128'd1000000;
   localparam logic [DIV_NUM_W-1:0] POW_WIDE = (128'd5255876 << F) / 128'd1000000;
   localparam logic [DIV_NUM_W-1:0] ALT_WIDE = (128'd4433077 << F) / 128'd100;
   localparam logic [WORD_W-1:0] C_LN2 = LN2_WIDE[WORD_W-1:0];
   localparam logic [WORD_W-1:0] C_EXP = EXP_WIDE[WORD_W-1:0];
   localparam logic [WORD_W-1:0] C_POW = POW_WIDE[WORD_W-1:0];
   localparam logic [WORD_W-1:0] C_ALT = ALT_WIDE[WORD_W-1:0];
   localparam logic [WORD_W-1:0] ONE = 64'd1 << F;
   localparam logic [WORD_W-1:0] FMASK = ONE - 64'd1;
   localparam logic [WORD_W-1:0] LOG_OFS = WORD_W'(F) << F;
   localparam logic [WORD_W:0] ROUND_HALF = 65'd1 << (F - 5);

   // saturate a 20-bit signed altitude into the 19-bit range
   function automatic logic signed [ALT_W-1:0] sat_alt(input logic signed [ALT_W:0] v);
      logic signed [ALT_W-1:0] r;
      if (v < (ALT_W+1)'(ALT_MIN)) begin
         r = ALT_MIN;
      end else if (v > (ALT_W+1)'(ALT_MAX)) begin
         r = ALT_MAX;
      end else begin
         r = v[ALT_W-1:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in, ret_ff, ret_in;

   // item and architectural state
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [PRES_W-1:0]        pv_ff, pv_in;
   logic signed [ALT_W-1:0]  known_ff, known_in;
   logic signed [OFS_W-1:0]  offset_ff, offset_in;
   logic [PRES_W-1:0]        pres_ff, pres_in;
   logic [PRES_W-1:0]        ref_ff, ref_in;
   logic signed [ALT_W-1:0]  base_ff, base_in;
   logic                     upd_ff, upd_in, err_ff, err_in;

   // working registers of the sequencer
   logic [WORD_W-1:0]        m_ff, m_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [F-1:0]             fr_ff, fr_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [WORD_W-1:0]        l1_ff, l1_in;
   logic [WORD_W-1:0]        val_ff, val_in;
   logic                     sgn_ff, sgn_in;
   logic signed [ALT_W:0]    h_ff, h_in;
   logic                     eneg_ff, eneg_in;
   logic [WORD_W-1:0]        s_ff, s_in, t_ff, t_in, y_ff, y_in;
   logic [K_W-1:0]           k_ff, k_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ALT_W-1:0]         rsp_alt_ff, rsp_alt_in;
   logic [PRES_W-1:0]        rsp_ref_ff, rsp_ref_in;
   logic                     rsp_upd_ff, rsp_upd_in, rsp_err_ff, rsp_err_in;

   // shared unit hookup
   logic                     mul_start, mul_done;
   logic [WORD_W-1:0]        mul_a, mul_b, mul_res;
   logic                     div_start, div_done;
   logic [DIV_NUM_W-1:0]     div_num;
   logic [WORD_W-1:0]        div_den, div_quo;

   bac_mul #(.FRAC_BITS(F)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start_i (mul_start),
      .a_i     (mul_a),
      .b_i     (mul_b),
      .done_o  (mul_done),
      .res_o   (mul_res)
   );

   bac_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start_i (div_start),
      .num_i   (div_num),
      .den_i   (div_den),
      .done_o  (div_done),
      .quo_o   (div_quo)
   );

   logic [WORD_W-1:0]        log_val;
   logic signed [ALT_W-1:0]  cur_alt;
   logic                     req_xfer;

   assign log_val = (WORD_W'(n_ff) << F) | WORD_W'(fr_ff);
   assign cur_alt = sat_alt((ALT_W+1)'(base_ff) + (ALT_W+1)'(offset_ff));
   assign req_xfer = req_tvalid && req_tready;

   // next state and datapath
   always_comb begin
      logic [WORD_W-1:0] diff;
      logic [WORD_W-1:0] mag;
      logic [WORD_W:0]   wide;
      logic [WORD_W:0]   rmag;
      logic [ALT_W:0]    hmag;
      logic [26:0]       hm100;
      logic              big;

      state_in = state_ff;
      ret_in = ret_ff;
      kind_in = kind_ff;
      pv_in = pv_ff;
      known_in = known_ff;
      offset_in = offset_ff;
      pres_in = pres_ff;
      ref_in = ref_ff;
      base_in = base_ff;
      upd_in = upd_ff;
      err_in = err_ff;
      m_in = m_ff;
      n_in = n_ff;
      fr_in = fr_ff;
      cnt_in = cnt_ff;
      l1_in = l1_ff;
      val_in = val_ff;
      sgn_in = sgn_ff;
      h_in = h_ff;
      eneg_in = eneg_ff;
      s_in = s_ff;
      t_in = t_ff;
      y_in = y_ff;
      k_in = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_alt_in = rsp_alt_ff;
      rsp_ref_in = rsp_ref_ff;
      rsp_upd_in = rsp_upd_ff;
      rsp_err_in = rsp_err_ff;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      req_tready = (state_ff == ST_IDLE);
      diff = '0;
      mag = '0;
      wide = '0;
      rmag = '0;
      hmag = '0;
      hm100 = '0;
      big = 1'b0;

      // result transfer frees the output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // offset register write
      if (csr_valid) begin
         offset_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               kind_in = req_tuser[KIND_W-1:0];
               pv_in = req_tdata[PRES_W-1:0];
               known_in = req_tdata[PRES_W+ALT_W-1:PRES_W];
               upd_in = 1'b0;
               err_in = 1'b0;
               state_in = ST_DECIDE;
            end
         end

         // decide whether the item changes anything
         ST_DECIDE: begin
            state_in = ST_RESULT;
            case (kind_ff)
               KIND_SAMPLE: begin
                  if (pv_ff != pres_ff) begin
                     pres_in = pv_ff;
                     upd_in = 1'b1;
                     state_in = ST_ALT_START;
                  end
               end
               KIND_SET_REF: begin
                  if (pv_ff != ref_ff) begin
                     ref_in = pv_ff;
                     upd_in = 1'b1;
                     state_in = ST_ALT_START;
                  end
               end
               KIND_CALIBRATE: begin
                  if (known_ff != cur_alt) begin
                     state_in = ST_CAL_DIV;
                  end
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end

         // altitude from pressure and reference
         ST_ALT_START: begin
            if (pres_ff == '0) begin
               base_in = ALT_MAX;
               state_in = ST_RESULT;
            end else if (ref_ff == '0) begin
               base_in = ALT_MIN;
               state_in = ST_RESULT;
            end else begin
               m_in = WORD_W'(pres_ff);
               n_in = CNT_W'(F);
               ret_in = ST_ALT_LOG2;
               state_in = ST_LOG_NORM;
            end
         end

         ST_ALT_LOG2: begin
            l1_in = log_val;
            m_in = WORD_W'(ref_ff);
            n_in = CNT_W'(F);
            ret_in = ST_ALT_SMUL;
            state_in = ST_LOG_NORM;
         end

         ST_ALT_SMUL: begin
            diff = l1_ff - log_val;
            sgn_in = diff[WORD_W-1];
            mul_a = diff[WORD_W-1] ? (WORD_W'(0) - diff) : diff;
            mul_b = C_EXP;
            mul_start = 1'b1;
            state_in = ST_ALT_SMUL_W;
         end

         ST_ALT_SMUL_W: begin
            if (mul_done) begin
               val_in = sgn_ff ? (WORD_W'(0) - mul_res) : mul_res;
               ret_in = ST_ALT_H;
               state_in = ST_EXP_Y;
            end
         end

         ST_ALT_H: begin
            diff = ONE - s_ff;
            sgn_in = diff[WORD_W-1];
            mul_a = diff[WORD_W-1] ? (WORD_W'(0) - diff) : diff;
            mul_b = C_ALT;
            mul_start = 1'b1;
            state_in = ST_ALT_H_W;
         end

         // round to 1/16 m, ties away from zero, then saturate
         ST_ALT_H_W: begin
            if (mul_done) begin
               wide = {1'b0, mul_res} + ROUND_HALF;
               rmag = wide >> (F - 4);
               if (!sgn_ff) begin
                  base_in = (rmag > (WORD_W+1)'(ALT_MAX)) ? ALT_MAX : rmag[ALT_W-1:0];
               end else if (rmag > ((WORD_W+1)'(0) - (WORD_W+1)'(ALT_MIN))) begin
                  base_in = ALT_MIN;
               end else begin
                  base_in = ALT_W'(0) - rmag[ALT_W-1:0];
               end
               state_in = ST_RESULT;
            end
         end

         // calibration: q = |h| / 44330.77 m in fixed point
         ST_CAL_DIV: begin
            h_in = (ALT_W+1)'(known_ff) - (ALT_W+1)'(offset_ff);
            hmag = h_in[ALT_W] ? ((ALT_W+1)'(0) - h_in) : h_in;
            hm100 = 27'(hmag) * 27'd100;
            div_num = DIV_NUM_W'(hm100) << F;
            div_den = CAL_DIVISOR;
            div_start = 1'b1;
            state_in = ST_CAL_DIV_W;
         end

         ST_CAL_DIV_W: begin
            if (div_done) begin
               if ((pres_ff == '0) || (!h_ff[ALT_W] && (div_quo >= ONE))) begin
                  err_in = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  m_in = h_ff[ALT_W] ? (ONE + div_quo) : (ONE - div_quo);
                  n_in = CNT_W'(F);
                  ret_in = ST_CAL_SMUL;
                  state_in = ST_LOG_NORM;
               end
            end
         end

         ST_CAL_SMUL: begin
            diff = log_val - LOG_OFS;
            sgn_in = diff[WORD_W-1];
            mul_a = diff[WORD_W-1] ? (WORD_W'(0) - diff) : diff;
            mul_b = C_POW;
            mul_start = 1'b1;
            state_in = ST_CAL_SMUL_W;
         end

         ST_CAL_SMUL_W: begin
            if (mul_done) begin
               val_in = sgn_ff ? (WORD_W'(0) - mul_res) : mul_res;
               ret_in = ST_CAL_P0;
               state_in = ST_EXP_Y;
            end
         end

         ST_CAL_P0: begin
            if (s_ff == '0) begin
               ref_in = P_MAX;
               base_in = sat_alt(h_ff);
               upd_in = 1'b1;
               state_in = ST_RESULT;
            end else begin
               div_num = DIV_NUM_W'(pres_ff) << (F + 1);
               div_den = s_ff;
               div_start = 1'b1;
               state_in = ST_CAL_P0_W;
            end
         end

         // reference rounded to nearest and saturated
         ST_CAL_P0_W: begin
            if (div_done) begin
               wide = ({1'b0, div_quo} + 65'd1) >> 1;
               ref_in = (wide > (WORD_W+1)'(P_MAX)) ? P_MAX : wide[PRES_W-1:0];
               base_in = sat_alt(h_ff);
               upd_in = 1'b1;
               state_in = ST_RESULT;
            end
         end

         // log2: bring the mantissa into [1, 2)
         ST_LOG_NORM: begin
            if ((m_ff >> (F + 1)) != '0) begin
               m_in = m_ff >> 1;
               n_in = n_ff + 7'd1;
            end else if ((m_ff >> F) == '0) begin
               m_in = m_ff << 1;
               n_in = n_ff - 7'd1;
            end else begin
               cnt_in = CNT_W'(F);
               state_in = ST_LOG_SQ;
            end
         end

         ST_LOG_SQ: begin
            mul_a = m_ff;
            mul_b = m_ff;
            mul_start = 1'b1;
            state_in = ST_LOG_SQ_W;
         end

         // one fraction bit per squaring
         ST_LOG_SQ_W: begin
            if (mul_done) begin
               big = ((mul_res >> (F + 1)) != '0);
               fr_in = {fr_ff[F-2:0], big};
               m_in = big ? (mul_res >> 1) : mul_res;
               cnt_in = cnt_ff - 7'd1;
               state_in = (cnt_ff == 7'd1) ? ret_ff : ST_LOG_SQ;
            end
         end

         // 2^x: split into integer shift and fraction, y = f * ln2
         ST_EXP_Y: begin
            eneg_in = val_ff[WORD_W-1];
            mag = val_ff[WORD_W-1] ? (WORD_W'(0) - val_ff) : val_ff;
            if (!val_ff[WORD_W-1]) begin
               wide = {1'b0, mag} >> F;
               cnt_in = (wide > (WORD_W+1)'(SHIFT_CAP_POS)) ? SHIFT_CAP_POS
                                                            : wide[CNT_W-1:0];
               mul_a = mag & FMASK;
            end else begin
               wide = ({1'b0, mag} + {1'b0, FMASK}) >> F;
               cnt_in = (wide > (WORD_W+1)'(SHIFT_CAP_NEG)) ? SHIFT_CAP_NEG
                                                            : wide[CNT_W-1:0];
               mul_a = (WORD_W'(0) - mag) & FMASK;
            end
            mul_b = C_LN2;
            mul_start = 1'b1;
            state_in = ST_EXP_Y_W;
         end

         ST_EXP_Y_W: begin
            if (mul_done) begin
               y_in = mul_res;
               t_in = ONE;
               s_in = ONE;
               k_in = 5'd1;
               state_in = ST_EXP_T;
            end
         end

         // series term t = t * y / k
         ST_EXP_T: begin
            mul_a = t_ff;
            mul_b = y_ff;
            mul_start = 1'b1;
            state_in = ST_EXP_T_W;
         end

         ST_EXP_T_W: begin
            if (mul_done) begin
               div_num = DIV_NUM_W'(mul_res);
               div_den = WORD_W'(k_ff);
               div_start = 1'b1;
               state_in = ST_EXP_K_W;
            end
         end

         ST_EXP_K_W: begin
            if (div_done) begin
               t_in = div_quo;
               s_in = s_ff + div_quo;
               if (k_ff == SERIES_TERMS) begin
                  state_in = ST_EXP_SH;
               end else begin
                  k_in = k_ff + 5'd1;
                  state_in = ST_EXP_T;
               end
            end
         end

         // apply the integer part one bit per cycle
         ST_EXP_SH: begin
            if (cnt_ff == '0) begin
               state_in = ret_ff;
            end else begin
               s_in = eneg_ff ? (s_ff >> 1) : (s_ff << 1);
               cnt_in = cnt_ff - 7'd1;
            end
         end

         // load the result once the output register is free
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_alt_in = cur_alt;
               rsp_ref_in = ref_ff;
               rsp_upd_in = upd_ff;
               rsp_err_in = err_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         offset_ff <= '0;
         pres_ff <= '0;
         ref_ff <= REF_RESET;
         base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         offset_ff <= offset_in;
         pres_ff <= pres_in;
         ref_ff <= ref_in;
         base_ff <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      pv_ff <= pv_in;
      known_ff <= known_in;
      upd_ff <= upd_in;
      err_ff <= err_in;
      m_ff <= m_in;
      n_ff <= n_in;
      fr_ff <= fr_in;
      cnt_ff <= cnt_in;
      l1_ff <= l1_in;
      val_ff <= val_in;
      sgn_ff <= sgn_in;
      h_ff <= h_in;
      eneg_ff <= eneg_in;
      s_ff <= s_in;
      t_ff <= t_in;
      y_ff <= y_in;
      k_ff <= k_in;
      rsp_alt_ff <= rsp_alt_in;
      rsp_ref_ff <= rsp_ref_in;
      rsp_upd_ff <= rsp_upd_in;
      rsp_err_ff <= rsp_err_in;
   end

   // output ports
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {(TDATA_W - PRES_W - ALT_W)'(0), rsp_ref_ff, rsp_alt_ff};
   assign rsp_tuser = {rsp_err_ff, rsp_upd_ff};

endmodule

`default_nettype wire

// ===== src/bac_mul.sv =====
// iterative fixed-point multiplier: (a * b) >> FRAC_BITS from four 32x32 partial products
`default_nettype none

module bac_mul #(
   parameter int unsigned FRAC_BITS = 30
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start_i,
   input  wire [bac_pkg::WORD_W-1:0]  a_i,
   input  wire [bac_pkg::WORD_W-1:0]  b_i,
   output logic                       done_o,
   output logic [bac_pkg::WORD_W-1:0] res_o
);
   import bac_pkg::*;

   localparam int unsigned HALF = WORD_W / 2;
   localparam int unsigned ACC_W = 2 * WORD_W;

   logic [WORD_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [2:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [HALF-1:0]   pa, pb;
   logic [ACC_W-1:0]  addend;

   // half selection for the current partial product
   always_comb begin
      case (step_ff)
         3'd0: begin
            pa = a_ff[HALF-1:0];
            pb = b_ff[HALF-1:0];
         end
         3'd1: begin
            pa = a_ff[HALF-1:0];
            pb = b_ff[WORD_W-1:HALF];
         end
         3'd2: begin
            pa = a_ff[WORD_W-1:HALF];
            pb = b_ff[HALF-1:0];
         end
         3'd3: begin
            pa = a_ff[WORD_W-1:HALF];
            pb = b_ff[WORD_W-1:HALF];
         end
         default: begin
            pa = '0;
            pb = '0;
         end
      endcase
   end

   // previous partial product aligned to its weight
   always_comb begin
      case (step_ff)
         3'd1:    addend = ACC_W'(prod_ff);
         3'd2:    addend = ACC_W'(prod_ff) << HALF;
         3'd3:    addend = ACC_W'(prod_ff) << HALF;
         3'd4:    addend = ACC_W'(prod_ff) << WORD_W;
         default: addend = '0;
      endcase
   end

   // step control and accumulation
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start_i) begin
         a_in = a_i;
         b_in = b_i;
         acc_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = WORD_W'(pa) * WORD_W'(pb);
         acc_in = acc_ff + addend;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign done_o = done_ff;
   assign res_o = acc_ff[FRAC_BITS+WORD_W-1:FRAC_BITS];

endmodule

`default_nettype wire

// ===== src/bac_div.sv =====
// restoring divider, one quotient bit per cycle, 128-bit dividend over 64-bit divisor
`default_nettype none

module bac_div (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start_i,
   input  wire [bac_pkg::DIV_NUM_W-1:0]  num_i,
   input  wire [bac_pkg::WORD_W-1:0]     den_i,
   output logic                          done_o,
   output logic [bac_pkg::WORD_W-1:0]    quo_o
);
   import bac_pkg::*;

   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;
   logic              fits;

   // one subtract-and-compare step
   always_comb begin
      trial = {rem_ff, quo_ff[WORD_W-1]};
      diff = trial - {1'b0, den_ff};
      fits = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start_i) begin
         rem_in = num_i[DIV_NUM_W-1:WORD_W];
         quo_in = num_i[WORD_W-1:0];
         den_in = den_i;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], fits};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done_o = done_ff;
   assign quo_o = quo_ff;

endmodule

`default_nettype wire

// ===== tb/barometric_altitude_with_calibration_unit_tb.sv =====
// self-checking testbench for the barometric altitude unit with calibration
module barometric_altitude_with_calibration_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bac_pkg::*;

   localparam int unsigned FB = 30;
   localparam logic [63:0] FX_ONE = 64'd1 << FB;
   localparam logic [63:0] FX_FMASK = FX_ONE - 64'd1;
   localparam int unsigned HOLD_OFF_CYCLES = 6000;
   localparam int unsigned ITEMS_PER_PHASE = 130;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // altimeter result as seen on the output stream
   typedef struct packed {
      logic [ALT_W-1:0]  altitude;
      logic [PRES_W-1:0] ref_pres;
      logic              updated;
      logic              cal_error;
   } alt_result_type;

   // one row of the directed stimulus
   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [PRES_W-1:0]        pres;
      logic signed [ALT_W-1:0]  known;
      bit                       known_is_current;
      bit                       typed;
      alt_result_type           typed_result;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata;
   logic [TUSER_W-1:0]  req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [TDATA_W-1:0]  rsp_tdata;
   logic [TUSER_W-1:0]  rsp_tuser;
   logic                csr_valid;
   logic                csr_ready;
   logic [OFS_W-1:0]    csr_wdata;

   // predictor state
   logic [63:0]  pred_pressure;
   logic [63:0]  pred_reference;
   longint       pred_base_alt;
   longint       pred_offset;
   logic [63:0]  k_exp_coef, k_cal_coef, k_scale, k_ln2;

   alt_result_type  altitude_expect_q[$];
   stim_row_type    directed_rows[$];
   int              mismatch_count;
   int              results_seen;
   bit              quiet_phase;

   barometric_altitude_with_calibration_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // fixed-point helpers
   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> FB;
      return p[63:0];
   endfunction

   function automatic logic [63:0] fx_div_shift(input logic [63:0] n, input int unsigned s,
                                                input logic [63:0] d);
      logic [127:0] t;
      t = ({64'd0, n} << s) / {64'd0, d};
      return t[63:0];
   endfunction

   function automatic longint fx_smul(input longint a, input logic [63:0] c);
      logic [63:0] m;
      logic [63:0] r;
      m = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
      r = fx_mul(m, c);
      return (a < 0) ? -longint'(r) : longint'(r);
   endfunction

   // log2 of a positive integer by mantissa squaring
   function automatic longint fx_log2(input logic [63:0] x);
      int unsigned n;
      logic [63:0] m;
      logic [63:0] fr;
      n = 0;
      fr = 64'd0;
      while (n < 63 && (x >> (n + 1)) != 64'd0) n++;
      m = (n <= FB) ? x << (FB - n) : x >> (n - FB);
      for (int i = 0; i < FB; i++) begin
         m = fx_mul(m, m);
         fr = fr << 1;
         if (m >= 2 * FX_ONE) begin
            m = m >> 1;
            fr = fr | 64'd1;
         end
      end
      return longint'((64'(n) << FB) | fr);
   endfunction

   // 2^e by a series of e^(f ln2)
   function automatic logic [63:0] fx_exp2(input longint e);
      logic [63:0] mag, ip, f, y, t, s;
      bit neg;
      neg = e < 0;
      mag = neg ? 64'd0 - 64'(e) : 64'(e);
      if (!neg) begin
         ip = mag >> FB;
         f = mag & FX_FMASK;
      end else begin
         ip = (mag + FX_FMASK) >> FB;
         f = (64'd0 - mag) & FX_FMASK;
      end
      y = fx_mul(f, k_ln2);
      t = FX_ONE;
      s = FX_ONE;
      for (int k = 1; k <= 24; k++) begin
         t = fx_mul(t, y) / 64'(k);
         s = s + t;
      end
      if (!neg) return s << ((ip > 64'd20) ? 64'd20 : ip);
      return (ip >= 64'd63) ? 64'd0 : s >> ip;
   endfunction

   function automatic longint clamp_alt(input longint v);
      if (v < -131072) return -131072;
      if (v > 262143) return 262143;
      return v;
   endfunction

   // altitude in 1/16 m without offset
   function automatic longint altitude_from_pressure(input logic [63:0] p,
                                                     input logic [63:0] r);
      longint l, h;
      logic [63:0] mag;
      bit neg;
      if (p == 64'd0) return 262143;
      if (r == 64'd0) return -131072;
      l = fx_log2(p) - fx_log2(r);
      h = longint'(FX_ONE) - longint'(fx_exp2(fx_smul(l, k_exp_coef)));
      h = fx_smul(h, k_scale);
      neg = h < 0;
      mag = neg ? 64'd0 - 64'(h) : 64'(h);
      mag = (mag + (64'd1 << (FB - 5))) >> (FB - 4);
      if (mag > 64'd300000) mag = 64'd300000;
      return clamp_alt(neg ? -longint'(mag) : longint'(mag));
   endfunction

   function automatic logic signed [ALT_W-1:0] reported_altitude();
      return ALT_W'(clamp_alt(pred_base_alt + pred_offset));
   endfunction

   // advance the predicted altimeter state by one item
   function automatic alt_result_type altimeter_step(input logic [KIND_W-1:0] kind,
                                                     input logic [PRES_W-1:0] pres,
                                                     input logic signed [ALT_W-1:0] known);
      alt_result_type res;
      longint h, lb;
      logic [63:0] hm, q, base, d, p0;
      res.updated = 1'b0;
      res.cal_error = 1'b0;
      case (kind)
         KIND_SAMPLE: begin
            if (64'(pres) != pred_pressure) begin
               pred_pressure = 64'(pres);
               pred_base_alt = altitude_from_pressure(pred_pressure, pred_reference);
               res.updated = 1'b1;
            end
         end
         KIND_SET_REF: begin
            if (64'(pres) != pred_reference) begin
               pred_reference = 64'(pres);
               pred_base_alt = altitude_from_pressure(pred_pressure, pred_reference);
               res.updated = 1'b1;
            end
         end
         KIND_CALIBRATE: begin
            if (longint'(known) != clamp_alt(pred_base_alt + pred_offset)) begin
               h = longint'(known) - pred_offset;
               hm = (h < 0) ? 64'(-h) : 64'(h);
               q = fx_div_shift(hm * 64'd100, FB, CAL_DIVISOR);
               if (pred_pressure == 64'd0 || (h >= 0 && q >= FX_ONE)) begin
                  res.cal_error = 1'b1;
               end else begin
                  base = (h >= 0) ? FX_ONE - q : FX_ONE + q;
                  lb = fx_log2(base) - longint'(64'(FB) << FB);
                  d = fx_exp2(fx_smul(lb, k_cal_coef));
                  p0 = 64'(P_MAX);
                  if (d != 64'd0) begin
                     p0 = (fx_div_shift(pred_pressure, FB + 1, d) + 64'd1) >> 1;
                     if (p0 > 64'(P_MAX)) p0 = 64'(P_MAX);
                  end
                  pred_reference = p0;
                  pred_base_alt = clamp_alt(h);
                  res.updated = 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.altitude = reported_altitude();
      res.ref_pres = pred_reference[PRES_W-1:0];
      return res;
   endfunction

   // offer one item, wait for its transfer, then queue the expected result
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PRES_W-1:0] pres,
                            input logic signed [ALT_W-1:0] known, input bit typed,
                            input alt_result_type typed_result);
      int gap;
      alt_result_type res;
      gap = quiet_phase ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, known, pres};
      do @(posedge clock); while (!req_tready);
      res = altimeter_step(kind, pres, known);
      altitude_expect_q.push_back(typed ? typed_result : res);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (altitude_expect_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_offset(input logic signed [OFS_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pred_offset = longint'(value);
   endtask

   function automatic void add_row(input logic [KIND_W-1:0] kind,
                                   input logic [PRES_W-1:0] pres,
                                   input logic signed [ALT_W-1:0] known,
                                   input bit known_is_current, input bit typed,
                                   input logic [ALT_W-1:0] alt, input logic [PRES_W-1:0] rp,
                                   input logic upd, input logic err);
      stim_row_type row;
      row.kind = kind;
      row.pres = pres;
      row.known = known;
      row.known_is_current = known_is_current;
      row.typed = typed;
      row.typed_result = '{altitude: alt, ref_pres: rp, updated: upd, cal_error: err};
      directed_rows.push_back(row);
   endfunction

   // random item, mostly plausible pressures and altitudes near the current one
   task automatic send_random_item();
      logic [KIND_W-1:0] kind;
      logic [PRES_W-1:0] pres;
      logic signed [ALT_W-1:0] known;
      int sel;
      sel = $urandom_range(0, 99);
      kind = (sel < 45) ? KIND_SAMPLE : (sel < 72) ? KIND_CALIBRATE :
             (sel < 94) ? KIND_SET_REF : KIND_UNUSED;
      sel = $urandom_range(0, 99);
      if (sel < 10) pres = (kind == KIND_SET_REF) ? pred_reference[18:0] : pred_pressure[18:0];
      else if (sel < 75) pres = (kind == KIND_SET_REF) ? PRES_W'($urandom_range(370000, 420000))
                                                       : PRES_W'($urandom_range(280000, 420000));
      else pres = PRES_W'($urandom());
      sel = $urandom_range(0, 99);
      if (sel < 10) known = reported_altitude();
      else if (sel < 70) known = ALT_W'(longint'(reported_altitude()) +
                                        longint'($urandom_range(0, 16000)) - 8000);
      else known = ALT_W'($urandom());
      send_item(kind, pres, known, 1'b0, '0);
   endtask

   // result side: random stalls, one long hold-off to back the block up
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         n = (results_seen == 60) ? HOLD_OFF_CYCLES :
             quiet_phase ? 0 : $urandom_range(0, 13);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      alt_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{altitude: rsp_tdata[18:0], ref_pres: rsp_tdata[37:19],
                 updated: rsp_tuser[0], cal_error: rsp_tuser[1]};
         results_seen <= results_seen + 1;
         if (altitude_expect_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result alt=%0d ref=%0d upd=%0b err=%0b", $time,
                     $signed(got.altitude), got.ref_pres, got.updated, got.cal_error);
         end else begin
            want = altitude_expect_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               $display({"%0t: expected alt=%0d ref=%0d upd=%0b err=%0b, ",
                         "got alt=%0d ref=%0d upd=%0b err=%0b"},
                        $time, $signed(want.altitude), want.ref_pres, want.updated,
                        want.cal_error, $signed(got.altitude), got.ref_pres, got.updated,
                        got.cal_error);
            end
         end
      end
   end

   // run limit
   initial begin
      #(64'd200_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus
   initial begin
      logic signed [ALT_W-1:0] kn;
      logic signed [OFS_W-1:0] phase_offsets[4];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      mismatch_count = 0;
      results_seen = 0;
      quiet_phase = 1'b0;
      pred_pressure = 64'd0;
      pred_reference = 64'(REF_RESET);
      pred_base_alt = 0;
      pred_offset = 0;
      k_exp_coef = fx_div_shift(64'd190263, FB, 64'd1000000);
      k_cal_coef = fx_div_shift(64'd5255876, FB, 64'd1000000);
      k_scale = fx_div_shift(64'd4433077, FB, 64'd100);
      k_ln2 = fx_div_shift(64'd69314718056, FB, 64'd100000000000);

      // directed rows: typed where the result is plain from reset or saturation
      add_row(KIND_SAMPLE, 19'd0, 19'sd0, 0, 1, 19'd0, REF_RESET, 0, 0);
      add_row(KIND_CALIBRATE, 19'd0, 19'sd1600, 0, 1, 19'd0, REF_RESET, 0, 1);
      add_row(KIND_UNUSED, 19'h7FFFF, -19'sd1, 0, 1, 19'd0, REF_RESET, 0, 0);
      add_row(KIND_SET_REF, REF_RESET, 19'sd0, 0, 1, 19'd0, REF_RESET, 0, 0);
      add_row(KIND_SAMPLE, P_MAX, 19'sd0, 0, 0, '0, '0, 0, 0);
      add_row(KIND_SAMPLE, REF_RESET, 19'sd0, 0, 0, '0, '0, 0, 0);
      add_row(KIND_SAMPLE, 19'd1, 19'sd0, 0, 0, '0, '0, 0, 0);
      add_row(KIND_SAMPLE, 19'd360000, 19'sd0, 0, 0, '0, '0, 0, 0);
      add_row(KIND_CALIBRATE, 19'd0, 19'sd0, 1, 0, '0, '0, 0, 0);
      add_row(KIND_CALIBRATE, 19'd0, ALT_MAX, 0, 0, '0, '0, 0, 0);
      add_row(KIND_CALIBRATE, 19'd0, ALT_MIN, 0, 0, '0, '0, 0, 0);
      add_row(KIND_CALIBRATE, 19'd0, 19'sd0, 0, 0, '0, '0, 0, 0);
      add_row(KIND_SET_REF, 19'd0, 19'sd0, 0, 1, ALT_MIN, 19'd0, 1, 0);
      add_row(KIND_SAMPLE, 19'd0, 19'sd0, 0, 1, ALT_MAX, 19'd0, 1, 0);
      add_row(KIND_SET_REF, P_MAX, 19'sd0, 0, 1, ALT_MAX, P_MAX, 1, 0);
      add_row(KIND_CALIBRATE, 19'd0, 19'sd4000, 0, 1, ALT_MAX, P_MAX, 0, 1);
      add_row(KIND_SAMPLE, 19'd400000, 19'sd0, 0, 0, '0, '0, 0, 0);
      add_row(KIND_CALIBRATE, 19'h7FFFF, 19'sd32000, 0, 0, '0, '0, 0, 0);
      add_row(KIND_SET_REF, REF_RESET, 19'sd0, 0, 0, '0, '0, 0, 0);
      add_row(KIND_UNUSED, 19'd0, 19'sd0, 0, 0, '0, '0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset offset
      foreach (directed_rows[i]) begin
         kn = directed_rows[i].known_is_current ? reported_altitude() : directed_rows[i].known;
         send_item(directed_rows[i].kind, directed_rows[i].pres, kn, directed_rows[i].typed,
                   directed_rows[i].typed_result);
      end

      // random phases, each under its own offset
      phase_offsets[0] = 17'sd65535;
      phase_offsets[1] = -17'sd65536;
      phase_offsets[2] = OFS_W'($urandom());
      phase_offsets[3] = 17'sd0;
      for (int ph = 0; ph < 4; ph++) begin
         write_offset(phase_offsets[ph]);
         quiet_phase = (ph == 2);
         repeat (ITEMS_PER_PHASE) send_random_item();
      end
      quiet_phase = 1'b0;

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && altitude_expect_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
